[hdl/tams_pkg.sv]
// ----------------------------------------------------------------------------
// tams_pkg
// shared types, widths, register indexes and reset values of the sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package tams_pkg;

    localparam int ADC_BITS_DEF = 14;
    localparam int ADC_IN_W     = 14;
    localparam int VALUE_W      = 18;
    localparam int TSC_W        = 17;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIALS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd4;

    localparam logic [19:0] WARMUP_RST   = 20'd3000;
    localparam logic [19:0] INTERVAL_RST = 20'd1000;
    localparam logic [7:0]  SAMPLES_RST  = 8'd5;
    localparam logic [7:0]  TRIALS_RST   = 8'd20;
    localparam logic [15:0] DEBOUNCE_RST = 16'd30;

    typedef enum logic [1:0] {
        PH_READY = 2'd0,
        PH_WARM  = 2'd1,
        PH_RUN   = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    typedef struct packed {
        logic step;
        logic div_start;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic need_div;
    } t_dp_stat;

    typedef struct packed {
        logic busy;
    } t_div_stat;

    typedef struct packed {
        logic               led_enable;
        t_phase             phase;
        logic [7:0]         trial_index;
        logic [7:0]         samples_taken;
        logic               reading_valid;
        logic [VALUE_W-1:0] reading_value;
        logic [7:0]         reading_trial;
        logic               run_complete;
    } t_result;

endpackage

`default_nettype wire

[hdl/tams_in_if.sv]
// ----------------------------------------------------------------------------
// tams_in_if
// tick channel: raw button level and converter sample
// ----------------------------------------------------------------------------
`default_nettype none

interface tams_in_if;
    logic                          valid;
    logic                          ready;
    logic                          button_level;
    logic [tams_pkg::ADC_IN_W-1:0] adc_sample;

    modport source (output valid, output button_level, output adc_sample, input ready);
    modport sink   (input valid, input button_level, input adc_sample, output ready);
endinterface

`default_nettype wire

[hdl/tams_out_if.sv]
// ----------------------------------------------------------------------------
// tams_out_if
// result channel: one status word per tick
// ----------------------------------------------------------------------------
`default_nettype none

interface tams_out_if;
    logic                         valid;
    logic                         ready;
    logic                         led_enable;
    logic [1:0]                   phase;
    logic [7:0]                   trial_index;
    logic [7:0]                   samples_taken;
    logic                         reading_valid;
    logic [tams_pkg::VALUE_W-1:0] reading_value;
    logic [7:0]                   reading_trial;
    logic                         run_complete;

    modport source (
        output valid, output led_enable, output phase, output trial_index,
        output samples_taken, output reading_valid, output reading_value,
        output reading_trial, output run_complete, input ready
    );
    modport sink (
        input valid, input led_enable, input phase, input trial_index,
        input samples_taken, input reading_valid, input reading_value,
        input reading_trial, input run_complete, output ready
    );
endinterface

`default_nettype wire

[hdl/tams_div.sv]
// ----------------------------------------------------------------------------
// tams_div
// restoring divider, one quotient bit per cycle, 8-bit divisor
// ----------------------------------------------------------------------------
`default_nettype none

module tams_div #(
    parameter int DW = 26
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [DW-1:0]       i_num,
    input  wire logic [7:0]          i_den,
    output tams_pkg::t_div_stat      o_stat,
    output logic [DW-1:0]            o_quo
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_quo;
    logic [7:0]       r_rem;
    logic [7:0]       r_den;
    logic [8:0]       trial;
    logic [8:0]       diff;
    logic             ge;

    assign trial = {r_rem, r_quo[DW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DW-2:0], ge};
            r_rem <= ge ? diff[7:0] : trial[7:0];
        end
    end

    assign o_stat.busy = r_cnt != '0;
    assign o_quo       = r_quo;

endmodule

`default_nettype wire

[hdl/tams_dp.sv]
// ----------------------------------------------------------------------------
// tams_dp
// datapath: configuration, debounce, warm-up and sampling counters, result word
// ----------------------------------------------------------------------------
`default_nettype none

module tams_dp #(
    parameter int ADC_BITS = tams_pkg::ADC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire tams_pkg::t_ctrl_cmd                 i_cmd,
    input  wire logic                                i_button_level,
    input  wire logic [tams_pkg::ADC_IN_W-1:0]       i_adc_sample,
    input  wire logic                                i_cfg_we,
    input  wire logic [tams_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [tams_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic [ADC_BITS+11:0]                i_quo,
    output tams_pkg::t_dp_stat                       o_stat,
    output logic [ADC_BITS+11:0]                     o_div_num,
    output logic [7:0]                               o_div_den,
    output tams_pkg::t_result                        o_result
);

    localparam int SUM_W = ADC_BITS + 8;
    localparam int SB    = (ADC_BITS < tams_pkg::ADC_IN_W) ? ADC_BITS : tams_pkg::ADC_IN_W;
    localparam logic [tams_pkg::TSC_W-1:0] TSC_MAX = '1;

    logic [19:0] r_warmup_ticks;
    logic [19:0] r_sample_interval;
    logic [7:0]  r_samples_per_trial;
    logic [7:0]  r_trials_per_run;
    logic [15:0] r_debounce_ticks;

    tams_pkg::t_phase            r_phase, n_phase;
    logic                        r_stable, n_stable;
    logic [tams_pkg::TSC_W-1:0]  r_tsc, n_tsc;
    logic [19:0]                 r_warm, n_warm;
    logic [19:0]                 r_wait, n_wait;
    logic [7:0]                  r_cnt, n_cnt;
    logic [SUM_W-1:0]            r_sum, n_sum;
    logic [7:0]                  r_trial, n_trial;

    logic                        r_res_valid, n_res_valid;
    logic [7:0]                  r_res_trial, n_res_trial;
    logic                        r_res_complete, n_res_complete;

    tams_pkg::t_result           r_out;

    logic                        chg;
    logic                        press;
    logic [tams_pkg::TSC_W-1:0]  tsc_a;
    tams_pkg::t_phase            phase_a;
    logic [19:0]                 warm_a;
    logic [7:0]                  trial_a;
    logic [SUM_W-1:0]            sample_x;
    logic [SUM_W-1:0]            sum_s;
    logic [7:0]                  cnt_s;
    logic [7:0]                  trial_s;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warmup_ticks      <= tams_pkg::WARMUP_RST;
            r_sample_interval   <= tams_pkg::INTERVAL_RST;
            r_samples_per_trial <= tams_pkg::SAMPLES_RST;
            r_trials_per_run    <= tams_pkg::TRIALS_RST;
            r_debounce_ticks    <= tams_pkg::DEBOUNCE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tams_pkg::CFG_WARMUP:   r_warmup_ticks      <= i_cfg_data[19:0];
                tams_pkg::CFG_INTERVAL: r_sample_interval   <= i_cfg_data[19:0];
                tams_pkg::CFG_SAMPLES:  r_samples_per_trial <= i_cfg_data[7:0];
                tams_pkg::CFG_TRIALS:   r_trials_per_run    <= i_cfg_data[7:0];
                tams_pkg::CFG_DEBOUNCE: r_debounce_ticks    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign sample_x = SUM_W'(i_adc_sample[SB-1:0]);
    assign sum_s    = r_sum + sample_x;
    assign cnt_s    = r_cnt + 8'd1;
    assign trial_s  = trial_a + 8'd1;

    always_comb begin
        chg     = (i_button_level != r_stable) &&
                  (r_tsc > {1'b0, r_debounce_ticks});
        press   = chg && !i_button_level &&
                  (r_phase == tams_pkg::PH_READY || r_phase == tams_pkg::PH_DONE);
        n_stable = chg ? i_button_level : r_stable;
        tsc_a    = chg ? '0 : r_tsc;
        n_tsc    = (tsc_a == TSC_MAX) ? tsc_a : tsc_a + 1'b1;
        phase_a  = press ? tams_pkg::PH_WARM : r_phase;
        warm_a   = press ? r_warmup_ticks : r_warm;
        trial_a  = press ? 8'd0 : r_trial;

        n_phase        = phase_a;
        n_warm         = warm_a;
        n_wait         = r_wait;
        n_cnt          = r_cnt;
        n_sum          = r_sum;
        n_trial        = trial_a;
        n_res_valid    = 1'b0;
        n_res_trial    = 8'd0;
        n_res_complete = 1'b0;

        case (phase_a)
            tams_pkg::PH_WARM: begin
                if (warm_a == 20'd0) begin
                    n_cnt   = 8'd0;
                    n_sum   = '0;
                    n_wait  = 20'd0;
                    n_phase = tams_pkg::PH_RUN;
                end else begin
                    n_warm = warm_a - 20'd1;
                end
            end
            tams_pkg::PH_RUN: begin
                if (r_wait == 20'd0) begin
                    n_wait = (r_sample_interval == 20'd0) ? 20'd0
                                                          : r_sample_interval - 20'd1;
                    n_sum  = sum_s;
                    n_cnt  = cnt_s;
                    if (cnt_s >= r_samples_per_trial) begin
                        n_res_valid = 1'b1;
                        n_res_trial = trial_s;
                        n_trial     = trial_s;
                        n_cnt       = 8'd0;
                        n_sum       = '0;
                        if (trial_s >= r_trials_per_run) begin
                            n_phase        = tams_pkg::PH_DONE;
                            n_res_complete = 1'b1;
                        end
                    end
                end else begin
                    n_wait = r_wait - 20'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_stat.need_div = n_res_valid;
    assign o_div_num       = {sum_s, 4'b0000};
    assign o_div_den       = (cnt_s == 8'd0) ? 8'd1 : cnt_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= tams_pkg::PH_READY;
            r_stable       <= 1'b1;
            r_tsc          <= '0;
            r_warm         <= '0;
            r_wait         <= '0;
            r_cnt          <= '0;
            r_sum          <= '0;
            r_trial        <= '0;
            r_res_valid    <= 1'b0;
            r_res_trial    <= '0;
            r_res_complete <= 1'b0;
        end else if (i_cmd.step) begin
            r_phase        <= n_phase;
            r_stable       <= n_stable;
            r_tsc          <= n_tsc;
            r_warm         <= n_warm;
            r_wait         <= n_wait;
            r_cnt          <= n_cnt;
            r_sum          <= n_sum;
            r_trial        <= n_trial;
            r_res_valid    <= n_res_valid;
            r_res_trial    <= n_res_trial;
            r_res_complete <= n_res_complete;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.led_enable    <= (r_phase == tams_pkg::PH_WARM) ||
                                   (r_phase == tams_pkg::PH_RUN);
            r_out.phase         <= r_phase;
            r_out.trial_index   <= r_trial;
            r_out.samples_taken <= r_cnt;
            r_out.reading_valid <= r_res_valid;
            r_out.reading_value <= r_res_valid ? i_quo[tams_pkg::VALUE_W-1:0] : '0;
            r_out.reading_trial <= r_res_trial;
            r_out.run_complete  <= r_res_complete;
        end
    end

    assign o_result = r_out;

endmodule

`default_nettype wire

[hdl/tams_ctrl.sv]
// ----------------------------------------------------------------------------
// tams_ctrl
// controller: accepts a tick, waits on the divider if the tick ends a trial, loads the output word
// ----------------------------------------------------------------------------
`default_nettype none

module tams_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_out_ready,
    input  wire tams_pkg::t_dp_stat   i_dp_stat,
    input  wire tams_pkg::t_div_stat  i_div_stat,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    output tams_pkg::t_ctrl_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PUT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free        = !r_out_valid || i_out_ready;
    assign o_in_ready       = r_state == S_IDLE;
    assign o_cmd.step       = o_in_ready && i_in_valid;
    assign o_cmd.div_start  = o_cmd.step && i_dp_stat.need_div;
    assign o_cmd.load_out   = (r_state == S_PUT) && slot_free;
    assign o_out_valid      = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.step) begin
                        r_state <= i_dp_stat.need_div ? S_DIV : S_PUT;
                    end
                end
                S_DIV: begin
                    if (!i_div_stat.busy) begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/timed_averaging_measurement_sequencer.sv]
// ----------------------------------------------------------------------------
// timed_averaging_measurement_sequencer
// button-started warm-up and averaged sampling sequencer, one word per tick
// ----------------------------------------------------------------------------
// usage
//   i_in carries one word per millisecond tick: button level and sample.
//   o_out returns one status word per accepted tick: LED enable, phase,
//   trial and sample counts, and on trial ends the average (4 fraction
//   bits, floor of sum*16/count), its trial number and run completion.
//   configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data
//   while no tick is in flight.
// sequence
//   a tick that ends no trial is accepted, then the output word is loaded.
//   a tick that ends a trial is accepted and starts the divider, which
//   forms one quotient bit per step over the ADC_BITS+12-bit dividend;
//   once the divider is seen to finish, the output word is loaded.
// reset
//   synchronous, active low: phase ready, button released, counters zero,
//   registers at their defaults, output empty.
// stall
//   the output word is registered; a new tick is taken while it waits,
//   and that tick's word is held back until the waiting one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_averaging_measurement_sequencer #(
    parameter int ADC_BITS = tams_pkg::ADC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    tams_in_if.sink                              i_in,
    tams_out_if.source                           o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [tams_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tams_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DW = ADC_BITS + 12;

    tams_pkg::t_ctrl_cmd  cmd;
    tams_pkg::t_dp_stat   dp_stat;
    tams_pkg::t_div_stat  div_stat;
    tams_pkg::t_result    result;
    logic [DW-1:0]        div_num;
    logic [7:0]           div_den;
    logic [DW-1:0]        div_quo;

    tams_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_dp_stat   (dp_stat),
        .i_div_stat  (div_stat),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    tams_dp #(
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_button_level (i_in.button_level),
        .i_adc_sample   (i_in.adc_sample),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_quo          (div_quo),
        .o_stat         (dp_stat),
        .o_div_num      (div_num),
        .o_div_den      (div_den),
        .o_result       (result)
    );

    tams_div #(
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    assign o_out.led_enable    = result.led_enable;
    assign o_out.phase         = result.phase;
    assign o_out.trial_index   = result.trial_index;
    assign o_out.samples_taken = result.samples_taken;
    assign o_out.reading_valid = result.reading_valid;
    assign o_out.reading_value = result.reading_value;
    assign o_out.reading_trial = result.reading_trial;
    assign o_out.run_complete  = result.run_complete;

`ifndef SYNTH
    a_no_accept_while_dividing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) div_stat.busy |-> !i_in.ready
    ) else $error("tick accepted while divider busy");

    a_reading_phase: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.reading_valid) |->
        (o_out.phase == tams_pkg::PH_RUN || o_out.phase == tams_pkg::PH_DONE)
    ) else $error("reading outside running or done");

    a_complete_with_reading: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.run_complete) |->
        (o_out.reading_valid && o_out.phase == tams_pkg::PH_DONE)
    ) else $error("run complete without final reading");
`endif

endmodule

`default_nettype wire

[bench/tams_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tams_checker
// watches the tick and status channels and the register port, predicts the
// status word of every accepted tick and compares it field by field with the
// word the sequencer returns
// ----------------------------------------------------------------------------

module tams_checker
    import tams_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tams_in_if                    i_in,
    tams_out_if                   i_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_ticks,
    output int                    o_readings,
    output int                    o_runs
);

    localparam int PRINT_CAP = 40;
    localparam logic [ADC_IN_W-1:0] ADC_MASK = ADC_IN_W'((1 << ADC_BITS_DEF) - 1);

    logic [19:0]  warmup_cfg;
    logic [19:0]  interval_cfg;
    logic [7:0]   samples_cfg;
    logic [7:0]   trials_cfg;
    logic [15:0]  debounce_cfg;

    t_phase       phase_q;
    logic         stable_level;
    logic [16:0]  since_change;
    logic [19:0]  warm_left;
    logic [19:0]  wait_left;
    logic [7:0]   sample_cnt;
    logic [21:0]  sample_acc;
    logic [7:0]   trial_cnt;

    t_result      expected_words[$];
    int           error_count;
    int           words_checked;
    int           tick_count;
    int           reading_count;
    int           run_count;

    function automatic t_result advance_tick(input logic lvl, input logic [ADC_IN_W-1:0] smp);
        t_result     w;
        logic [ADC_IN_W-1:0] s;
        logic [19:0] iv;
        logic [7:0]  cnt;
        logic [25:0] scaled;
        w = '0;
        s = smp & ADC_MASK;
        if (lvl != stable_level && since_change > {1'b0, debounce_cfg}) begin
            stable_level = lvl;
            since_change = '0;
            if (!lvl && (phase_q == PH_READY || phase_q == PH_DONE)) begin
                trial_cnt = '0;
                warm_left = warmup_cfg;
                phase_q   = PH_WARM;
            end
        end
        if (since_change != '1)
            since_change = since_change + 17'd1;
        case (phase_q)
            PH_WARM: begin
                // the sample of the tick that ends the warm-up is dropped
                if (warm_left == '0) begin
                    sample_cnt = '0;
                    sample_acc = '0;
                    wait_left  = '0;
                    phase_q    = PH_RUN;
                end else begin
                    warm_left = warm_left - 20'd1;
                end
            end
            PH_RUN: begin
                if (wait_left == '0) begin
                    iv         = (interval_cfg == '0) ? 20'd1 : interval_cfg;
                    wait_left  = iv - 20'd1;
                    sample_acc = sample_acc + 22'(s);
                    sample_cnt = sample_cnt + 8'd1;
                    if (sample_cnt >= samples_cfg) begin
                        cnt             = (sample_cnt == '0) ? 8'd1 : sample_cnt;
                        scaled          = {sample_acc, 4'b0000};
                        w.reading_valid = 1'b1;
                        w.reading_value = VALUE_W'(scaled / 26'(cnt));
                        w.reading_trial = trial_cnt + 8'd1;
                        trial_cnt       = trial_cnt + 8'd1;
                        sample_cnt      = '0;
                        sample_acc      = '0;
                        if (trial_cnt >= trials_cfg) begin
                            phase_q        = PH_DONE;
                            w.run_complete = 1'b1;
                        end
                    end
                end else begin
                    wait_left = wait_left - 20'd1;
                end
            end
            default: ;
        endcase
        w.led_enable    = (phase_q == PH_WARM || phase_q == PH_RUN);
        w.phase         = phase_q;
        w.trial_index   = trial_cnt;
        w.samples_taken = sample_cnt;
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("[%0t] status word %0d: %s", $realtime, words_checked, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            warmup_cfg    = WARMUP_RST;
            interval_cfg  = INTERVAL_RST;
            samples_cfg   = SAMPLES_RST;
            trials_cfg    = TRIALS_RST;
            debounce_cfg  = DEBOUNCE_RST;
            phase_q       = PH_READY;
            stable_level  = 1'b1;
            since_change  = '0;
            warm_left     = '0;
            wait_left     = '0;
            sample_cnt    = '0;
            sample_acc    = '0;
            trial_cnt     = '0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WARMUP:   warmup_cfg   = i_cfg_data[19:0];
                    CFG_INTERVAL: interval_cfg = i_cfg_data[19:0];
                    CFG_SAMPLES:  samples_cfg  = i_cfg_data[7:0];
                    CFG_TRIALS:   trials_cfg   = i_cfg_data[7:0];
                    CFG_DEBOUNCE: debounce_cfg = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                expected_words.push_back(advance_tick(i_in.button_level, i_in.adc_sample));
                tick_count++;
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("word arrived with nothing expected");
                end else begin
                    want = expected_words.pop_front();
                    check_field("led_enable", i_out.led_enable, want.led_enable);
                    check_field("phase", i_out.phase, want.phase);
                    check_field("trial_index", i_out.trial_index, want.trial_index);
                    check_field("samples_taken", i_out.samples_taken, want.samples_taken);
                    check_field("reading_valid", i_out.reading_valid, want.reading_valid);
                    check_field("reading_value", i_out.reading_value, want.reading_value);
                    check_field("reading_trial", i_out.reading_trial, want.reading_trial);
                    check_field("run_complete", i_out.run_complete, want.run_complete);
                    if (want.reading_valid)
                        reading_count++;
                    if (want.run_complete)
                        run_count++;
                end
                words_checked++;
            end
        end
        o_errors   <= error_count;
        o_pending  <= expected_words.size();
        o_ticks    <= tick_count;
        o_readings <= reading_count;
        o_runs     <= run_count;
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives button and sample ticks into the measurement sequencer through
// several register settings, from all-zero and per-field maximum extremes to small
// random ones, with random idling and back-pressure; the checker beside the
// block predicts every status word and counts mismatches for the verdict
// ----------------------------------------------------------------------------

module testbench;
    import tams_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RST_CYCLES  = 12;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 40;
    localparam int TOTAL_TICKS = 1424;
    localparam int CALM_AT     = TOTAL_TICKS - 250;
    localparam logic [ADC_IN_W-1:0] ADC_MAX = '1;
    localparam logic [19:0] REG20_MAX = '1;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int errors;
    int pending;
    int ticks_seen;
    int readings_seen;
    int runs_seen;

    bit jitter_on    = 1'b1;
    bit hold_off_req = 1'b0;
    int ticks_sent   = 0;
    int settings_used = 0;

    logic [15:0] cur_debounce;

    tams_in_if  tick_ch ();
    tams_out_if word_ch ();

    timed_averaging_measurement_sequencer u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (tick_ch),
        .o_out      (word_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    tams_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (tick_ch),
        .i_out      (word_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_ticks    (ticks_seen),
        .o_readings (readings_seen),
        .o_runs     (runs_seen)
    );

    always begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    function automatic logic [ADC_IN_W-1:0] pick_sample();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return ADC_MAX;
        return ADC_IN_W'($urandom_range(0, 16383));
    endfunction

    task automatic send_tick(input logic lvl, input logic [ADC_IN_W-1:0] smp);
        if (jitter_on && $urandom_range(0, 3) == 0) begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.button_level <= lvl;
        tick_ch.adc_sample   <= smp;
        do @(posedge clk); while (!tick_ch.ready);
        ticks_sent++;
    endtask

    task automatic send_level(input logic lvl, input int count);
        repeat (count) send_tick(lvl, pick_sample());
    endtask

    task automatic wait_idle();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_settings(input logic [19:0] warm, input logic [19:0] iv,
                                  input logic [7:0] spt, input logic [7:0] tpr,
                                  input logic [15:0] db);
        cur_debounce = db;
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_WARMUP;
        cfg_data <= warm;
        @(posedge clk);
        cfg_idx  <= CFG_INTERVAL;
        cfg_data <= iv;
        @(posedge clk);
        cfg_idx  <= CFG_SAMPLES;
        cfg_data <= CFG_DATA_W'(spt);
        @(posedge clk);
        cfg_idx  <= CFG_TRIALS;
        cfg_data <= CFG_DATA_W'(tpr);
        @(posedge clk);
        cfg_idx  <= CFG_DEBOUNCE;
        cfg_data <= CFG_DATA_W'(db);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    task automatic run_phase(input int n_ticks);
        int stop_at;
        int pick;
        int guard;
        stop_at = ticks_sent + n_ticks;
        while (ticks_sent < stop_at) begin
            pick  = $urandom_range(0, 9);
            guard = (cur_debounce > 16'd20) ? 20 : int'(cur_debounce);
            if (pick < 7) begin
                // clean press: settle released, hold pressed, then let go
                send_level(1'b1, guard + 1 + $urandom_range(0, 3));
                send_level(1'b0, guard + 1 + $urandom_range(0, 4));
                send_level(1'b1, $urandom_range(0, 40));
            end else if (pick < 9) begin
                repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(0, 1)), pick_sample());
            end else begin
                send_level(1'($urandom_range(0, 1)), $urandom_range(1, 20));
            end
            if (ticks_sent >= CALM_AT)
                jitter_on = 1'b0;
        end
    endtask

    initial begin
        word_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_off_req) begin
                word_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off_req = 1'b0;
            end else if (jitter_on && $urandom_range(0, 4) == 0) begin
                word_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end else begin
                word_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("timed_averaging_measurement_sequencer: mismatch");
        $finish;
    end

    initial begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= CFG_WARMUP;
        cfg_data             <= '0;
        tick_ch.valid        <= 1'b0;
        tick_ch.button_level <= 1'b1;
        tick_ch.adc_sample   <= '0;
        cur_debounce = DEBOUNCE_RST;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: a press right after reset is locked out
        send_tick(1'b1, '0);
        send_tick(1'b1, ADC_MAX);
        send_tick(1'b0, 14'h2aaa);
        send_tick(1'b0, 14'h1555);
        wait_idle();

        // all zero: warm-up ends on the press, one-sample trials, one-trial runs
        write_settings('0, '0, '0, '0, '0);
        send_tick(1'b1, 14'd5);
        send_tick(1'b0, ADC_MAX);
        send_tick(1'b0, ADC_MAX);
        send_tick(1'b1, '0);
        send_tick(1'b0, 14'd100);
        send_tick(1'b0, 14'd7);
        wait_idle();

        // presses while running are ignored, full-scale average
        write_settings(20'd2, 20'd2, 8'd3, 8'd2, 16'd1);
        send_tick(1'b1, ADC_MAX);
        send_tick(1'b1, ADC_MAX);
        send_tick(1'b0, ADC_MAX);
        send_tick(1'b0, ADC_MAX);
        send_tick(1'b1, ADC_MAX);
        send_tick(1'b1, ADC_MAX);
        send_tick(1'b0, ADC_MAX);
        send_tick(1'b0, ADC_MAX);
        send_tick(1'b0, ADC_MAX);
        send_tick(1'b1, ADC_MAX);
        send_tick(1'b1, ADC_MAX);
        send_tick(1'b0, ADC_MAX);
        send_tick(1'b0, ADC_MAX);
        send_tick(1'b1, ADC_MAX);
        wait_idle();

        for (int p = 0; ticks_sent < TOTAL_TICKS; p++) begin
            case (p)
                0: write_settings('0, '0, 8'd255, 8'd1, '0);
                1: write_settings(20'd3, 20'd1, '0, 8'd255, 16'd2);
                2: write_settings(20'd1, REG20_MAX, 8'd1, 8'd1, 16'd1);
                3: write_settings(20'd4, 20'd2, 8'd3, 8'd2, 16'hffff);
                default: write_settings(20'($urandom_range(0, 8)), 20'($urandom_range(0, 3)),
                                        8'($urandom_range(0, 6)), 8'($urandom_range(0, 4)),
                                        16'($urandom_range(0, 6)));
            endcase
            if (p == 4)
                hold_off_req = 1'b1;
            run_phase((p < 2) ? 300 : $urandom_range(60, 140));
            wait_idle();
        end

        // longest warm-up last: the run never leaves warming
        write_settings(REG20_MAX, 20'($urandom_range(0, 3)), 8'($urandom_range(0, 6)),
                       8'($urandom_range(0, 4)), '0);
        run_phase(40);
        wait_idle();

        $display("%0d ticks checked under %0d register settings", ticks_seen, settings_used);
        $display("%0d trial readings and %0d finished runs seen", readings_seen, runs_seen);
        if (errors == 0 && pending == 0) begin
            $display("timed_averaging_measurement_sequencer: match");
        end else begin
            if (pending != 0)
                $display("%0d expected words never arrived", pending);
            $display("timed_averaging_measurement_sequencer: mismatch");
        end
        $finish;
    end

endmodule
